// ----- src/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg: shared definitions for the bitmap frame allocator
// Field widths, opcodes, register indexes, reset values and the command and
// status words passed between controller and datapath.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int FRAME_COUNT_DEF = 1048576;
  localparam int WORD_WIDTH_DEF  = 32;

  localparam int FRAME_W    = 20;
  localparam int WSIZE_W    = 21;
  localparam int COUNT_W    = 21;
  localparam int OP_W       = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 21;
  localparam int DIFF_W     = FRAME_W + 3;

  localparam int BOOT_MARGIN = 128;

  localparam logic [FRAME_W-1:0] KERNEL_LAST_RST  = 20'd0;
  localparam logic [FRAME_W-1:0] WINDOW_START_RST = 20'd8;
  localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST  = 21'd120;

  localparam logic [CFG_ADDR_W-1:0] CFG_KERNEL_LAST  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_START = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_MARK  = 2'd1,
    OP_FREE  = 2'd2,
    OP_BOOT  = 2'd3
  } op_t;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic div;
    logic m_rd;
    logic m_mod;
    logic a_rd;
    logic a_step;
    logic a_commit;
    logic b_rd;
    logic b_mod;
    logic b_cnt;
    logic res_load;
    logic res_ok;
    logic res_alloc;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic fid_oob;
    logic hint_end;
    logic word_full;
    logic cand_oob;
    logic boot_last_word;
  } status_t;

endpackage

// ----- src/bfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfa_ctrl: allocator sequencer
// Runs the post-reset clearing pass and steps each operation through its
// read, modify and count cycles; raises the result strobe.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [bfa_pkg::OP_W-1:0]         opcode,
  input  bfa_pkg::status_t                 status,
  output bfa_pkg::cmd_t                    cmd,
  output logic                             busy,
  output logic                             done
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_DIV   = 10'b00_0000_0100,
    S_MRD   = 10'b00_0000_1000,
    S_MMOD  = 10'b00_0001_0000,
    S_ARD   = 10'b00_0010_0000,
    S_ACHK  = 10'b00_0100_0000,
    S_BRD   = 10'b00_1000_0000,
    S_BMOD  = 10'b01_0000_0000,
    S_BCNT  = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (bfa_pkg::op_t'(opcode))
            bfa_pkg::OP_ALLOC: state_next = S_ARD;
            bfa_pkg::OP_MARK:  state_next = S_DIV;
            bfa_pkg::OP_FREE:  state_next = S_DIV;
            bfa_pkg::OP_BOOT:  state_next = S_BRD;
            default:           state_next = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (status.fid_oob) begin
          cmd.res_load = 1'b1;
          cmd.res_ok   = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_MRD;
        end
      end
      S_MRD: begin
        cmd.m_rd   = 1'b1;
        state_next = S_MMOD;
      end
      S_MMOD: begin
        cmd.m_mod    = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_ok   = 1'b1;
        state_next   = S_IDLE;
      end
      S_ARD: begin
        if (status.hint_end) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.a_rd   = 1'b1;
          state_next = S_ACHK;
        end
      end
      S_ACHK: begin
        if (status.word_full) begin
          cmd.a_step = 1'b1;
          state_next = S_ARD;
        end else if (status.cand_oob) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.a_commit  = 1'b1;
          cmd.res_load  = 1'b1;
          cmd.res_ok    = 1'b1;
          cmd.res_alloc = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_BRD: begin
        cmd.b_rd   = 1'b1;
        state_next = S_BMOD;
      end
      S_BMOD: begin
        cmd.b_mod  = 1'b1;
        state_next = S_BCNT;
      end
      S_BCNT: begin
        cmd.b_cnt = 1'b1;
        if (status.boot_last_word) begin
          cmd.res_load = 1'b1;
          cmd.res_ok   = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_BRD;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.res_load;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- src/bfa_datapath.sv -----
// ----------------------------------------------------------------------------
// bfa_datapath: bitmap store, frame arithmetic and counters
// Holds the frame bitmap memory, configuration registers, used count,
// lowest-candidate word hint and result registers.
// ----------------------------------------------------------------------------
module bfa_datapath #(
  parameter int FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF,
  parameter int WORD_WIDTH  = bfa_pkg::WORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bfa_pkg::cmd_t                     cmd,
  output bfa_pkg::status_t                  status,
  input  logic [bfa_pkg::OP_W-1:0]          opcode,
  input  logic [bfa_pkg::FRAME_W-1:0]       frame_id,
  input  logic                              cfg_write,
  input  logic [bfa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bfa_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [bfa_pkg::FRAME_W-1:0]       alloc_frame,
  output logic                              alloc_ok,
  output logic [bfa_pkg::COUNT_W-1:0]       used_count
);

  localparam int FW         = bfa_pkg::FRAME_W;
  localparam int SW         = bfa_pkg::WSIZE_W;
  localparam int DW         = bfa_pkg::DIFF_W;
  localparam int OCW        = bfa_pkg::COUNT_W;
  localparam int WORD_COUNT = (FRAME_COUNT + WORD_WIDTH - 1) / WORD_WIDTH;
  localparam int AW         = $clog2(WORD_COUNT);
  localparam int BW         = $clog2(WORD_WIDTH);
  localparam int SH_W       = BW + 1;
  localparam int BASE_W     = $clog2(WORD_COUNT * WORD_WIDTH + 1);
  localparam int CNT_W      = $clog2(FRAME_COUNT + 1);
  localparam int POP_W      = $clog2(WORD_WIDTH + 1);
  localparam int DS         = FW + BW;
  localparam int M_W        = FW + 2;
  localparam int P_W        = FW + M_W;
  localparam logic [M_W-1:0] RECIP =
    M_W'(((64'd1 << DS) + 64'(WORD_WIDTH) - 64'd1) / 64'(WORD_WIDTH));

  function automatic logic [WORD_WIDTH-1:0] lt_mask(input logic signed [DW-1:0] n);
    logic [WORD_WIDTH-1:0] m;
    if (n <= 0) begin
      m = '0;
    end else if (n >= $signed(DW'(WORD_WIDTH))) begin
      m = '1;
    end else begin
      m = {WORD_WIDTH{1'b1}} >> (SH_W'(WORD_WIDTH) - SH_W'(n));
    end
    return m;
  endfunction

  function automatic logic [POP_W-1:0] popcount(input logic [WORD_WIDTH-1:0] w);
    logic [POP_W-1:0] c;
    c = '0;
    for (int i = 0; i < WORD_WIDTH; i++) begin
      c = c + POP_W'(w[i]);
    end
    return c;
  endfunction

  function automatic logic [BW-1:0] first_zero(input logic [WORD_WIDTH-1:0] w);
    logic [BW-1:0] idx;
    idx = '0;
    for (int i = WORD_WIDTH - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BW'(i);
      end
    end
    return idx;
  endfunction

  logic [WORD_WIDTH-1:0] mem [WORD_COUNT];
  logic [WORD_WIDTH-1:0] rdata;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic [WORD_WIDTH-1:0] wdata;

  logic [FW-1:0]         kernel_last;
  logic [FW-1:0]         window_start;
  logic [SW-1:0]         window_size;

  bfa_pkg::op_t          op_q;
  logic [FW-1:0]         fid_q;
  logic [P_W-1:0]        prod;
  logic [AW-1:0]         mq;
  logic [BW-1:0]         rem;
  logic [BASE_W-1:0]     qbase;
  logic [AW:0]           hint;
  logic [BASE_W-1:0]     hint_base;
  logic [AW-1:0]         widx;
  logic [BASE_W-1:0]     base;
  logic [FW-1:0]         boot_last;
  logic [FW-1:0]         wstart_q;
  logic [SW-1:0]         wend_q;
  logic [WORD_WIDTH-1:0] newbits;
  logic [CNT_W-1:0]      count;

  logic [FW-1:0]         q_full;
  logic [FW-1:0]         qmul;
  logic [SW-1:0]         last_sum;
  logic [FW-1:0]         last_c;
  logic [BW-1:0]         zero_pos;
  logic [BASE_W-1:0]     cand;
  logic [WORD_WIDTH-1:0] rem_bit;
  logic [WORD_WIDTH-1:0] zero_bit;
  logic                  bit_set;
  logic                  mark_chg;
  logic                  free_chg;
  logic signed [DW-1:0]  d_last;
  logic signed [DW-1:0]  d_ws;
  logic signed [DW-1:0]  d_we;
  logic [WORD_WIDTH-1:0] bmask;

  // word index by reciprocal multiply, remainder by back-multiply
  assign q_full   = FW'(prod >> DS);
  assign qmul     = FW'(q_full * FW'(WORD_WIDTH));

  assign last_sum = SW'(kernel_last) + SW'(bfa_pkg::BOOT_MARGIN);
  assign last_c   = (32'(last_sum) > 32'(FRAME_COUNT - 1)) ? FW'(FRAME_COUNT - 1)
                                                           : FW'(last_sum);

  assign zero_pos = first_zero(rdata);
  assign cand     = hint_base + BASE_W'(zero_pos);
  assign rem_bit  = WORD_WIDTH'(1) << rem;
  assign zero_bit = WORD_WIDTH'(1) << zero_pos;
  assign bit_set  = rdata[rem];
  assign mark_chg = (op_q == bfa_pkg::OP_MARK) && !bit_set;
  assign free_chg = (op_q == bfa_pkg::OP_FREE) && bit_set;

  assign d_last = $signed(DW'(boot_last)) - $signed(DW'(base));
  assign d_ws   = $signed(DW'(wstart_q)) - $signed(DW'(base));
  assign d_we   = $signed(DW'(wend_q)) - $signed(DW'(base));
  assign bmask  = lt_mask(d_last + DW'(1)) & ~(~lt_mask(d_ws) & lt_mask(d_we));

  always_comb begin
    status.clear_last     = (widx == AW'(WORD_COUNT - 1));
    status.fid_oob        = (32'(fid_q) >= 32'(FRAME_COUNT));
    status.hint_end       = (hint >= (AW + 1)'(WORD_COUNT));
    status.word_full      = &rdata;
    status.cand_oob       = (32'(cand) >= 32'(FRAME_COUNT));
    status.boot_last_word = (32'(base) + 32'(WORD_WIDTH) > 32'(boot_last));
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = widx;
    wdata  = '0;
    if (cmd.clear_wr) begin
      mem_we = 1'b1;
    end else if (cmd.m_mod) begin
      mem_we = mark_chg || free_chg;
      waddr  = mq;
      wdata  = mark_chg ? (rdata | rem_bit) : (rdata & ~rem_bit);
    end else if (cmd.a_commit) begin
      mem_we = 1'b1;
      waddr  = hint[AW-1:0];
      wdata  = rdata | zero_bit;
    end else if (cmd.b_mod) begin
      mem_we = 1'b1;
      wdata  = rdata | bmask;
    end
  end

  always_comb begin
    mem_re = cmd.a_rd || cmd.m_rd || cmd.b_rd;
    raddr  = widx;
    if (cmd.a_rd) begin
      raddr = hint[AW-1:0];
    end else if (cmd.m_rd) begin
      raddr = q_full[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_last  <= bfa_pkg::KERNEL_LAST_RST;
      window_start <= bfa_pkg::WINDOW_START_RST;
      window_size  <= bfa_pkg::WINDOW_SIZE_RST;
      count        <= '0;
      hint         <= '0;
      hint_base    <= '0;
      widx         <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_addr)
          bfa_pkg::CFG_KERNEL_LAST:  kernel_last  <= FW'(cfg_data);
          bfa_pkg::CFG_WINDOW_START: window_start <= FW'(cfg_data);
          bfa_pkg::CFG_WINDOW_SIZE:  window_size  <= SW'(cfg_data);
          default: ;
        endcase
      end
      if (cmd.load) begin
        widx <= '0;
      end else if (cmd.clear_wr || cmd.b_cnt) begin
        widx <= widx + AW'(1);
      end
      if (cmd.m_mod) begin
        if (mark_chg) begin
          count <= count + CNT_W'(1);
        end else if (free_chg) begin
          count <= count - CNT_W'(1);
        end
        if ((op_q == bfa_pkg::OP_FREE) && ({1'b0, mq} < hint)) begin
          hint      <= {1'b0, mq};
          hint_base <= qbase;
        end
      end
      if (cmd.a_step) begin
        hint      <= hint + (AW + 1)'(1);
        hint_base <= hint_base + BASE_W'(WORD_WIDTH);
      end
      if (cmd.a_commit) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.b_cnt) begin
        count <= count + CNT_W'(popcount(newbits));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= bfa_pkg::op_t'(opcode);
      fid_q     <= frame_id;
      boot_last <= last_c;
      wstart_q  <= window_start;
      wend_q    <= SW'(window_start) + window_size;
      base      <= '0;
    end else if (cmd.b_cnt) begin
      base <= base + BASE_W'(WORD_WIDTH);
    end
    if (cmd.div) begin
      prod <= P_W'(fid_q) * P_W'(RECIP);
    end
    if (cmd.m_rd) begin
      mq    <= q_full[AW-1:0];
      rem   <= BW'(fid_q - qmul);
      qbase <= BASE_W'(qmul);
    end
    if (cmd.b_mod) begin
      newbits <= bmask & ~rdata;
    end
    if (cmd.res_load) begin
      alloc_ok    <= cmd.res_ok;
      alloc_frame <= cmd.res_alloc ? FW'(cand) : '0;
    end
  end

  assign used_count = OCW'(count);

endmodule

// ----- src/bitmap_frame_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_frame_allocator: first-fit physical page frame allocator
// One used/free bit per frame, packed WORD_WIDTH frames to a memory word,
// with a running count of used frames.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word (opcode, frame_id) is taken on a clock edge with
//   start high and busy low. Busy stays high until the result is out.
//   Result channel: done pulses for one cycle with alloc_frame, alloc_ok and
//   used_count valid; the receiver cannot hold it off.
//   Config port: cfg_write/cfg_addr/cfg_data, taken on any edge. The user must
//   write it only while idle; the block itself does not enforce this.
// Steps (accept to done):
//   mark used / free: divide, read, modify, result; for a frame_id at or past
//     FRAME_COUNT the result comes straight after the divide.
//   allocate: a read and a check per word scanned, then the result. Scanning
//     starts at the lowest word that may hold a free frame, so usually one
//     word. With no word left to scan, the result is given without a read.
//   boot reserve: read, modify, count per word up to the last reserved frame.
//   A new command may be taken in the cycle done is high.
// Reset: rst (synchronous) resets registers, then a clearing pass zeroes
//   the bitmap one word per cycle, busy high throughout.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator #(
  parameter int FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF,
  parameter int WORD_WIDTH  = bfa_pkg::WORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [bfa_pkg::OP_W-1:0]          opcode,
  input  logic [bfa_pkg::FRAME_W-1:0]       frame_id,
  input  logic                              cfg_write,
  input  logic [bfa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bfa_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              done,
  output logic [bfa_pkg::FRAME_W-1:0]       alloc_frame,
  output logic                              alloc_ok,
  output logic [bfa_pkg::COUNT_W-1:0]       used_count
);

  bfa_pkg::cmd_t    cmd;
  bfa_pkg::status_t status;

  bfa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bfa_datapath #(
    .FRAME_COUNT (FRAME_COUNT),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .opcode      (opcode),
    .frame_id    (frame_id),
    .cfg_write   (cfg_write),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .alloc_frame (alloc_frame),
    .alloc_ok    (alloc_ok),
    .used_count  (used_count)
  );

endmodule
